### rtl/ipftp_pkg.sv
// Package for the IPv4 / IPv6 five-tuple parser.
// Holds protocol codes, fixed header offsets, length minimums and the result word type.
// No dependencies.
`default_nettype none

package ipftp_pkg;

	// default sizing, handed down from the top level
	localparam int MAX_PACKET_BYTES_DEF = 65535;
	localparam int MAX_EXT_HEADERS_DEF  = 8;

	// IP version nibbles
	localparam logic [3:0] VER_V4 = 4'd4;
	localparam logic [3:0] VER_V6 = 4'd6;

	// next-header / protocol codes
	localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTING    = 8'd43;
	localparam logic [7:0] NH_FRAGMENT   = 8'd44;
	localparam logic [7:0] NH_AUTH       = 8'd51;
	localparam logic [7:0] NH_DEST_OPT   = 8'd60;
	localparam logic [7:0] PROTO_ICMP    = 8'd1;
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] PROTO_UDP     = 8'd17;
	localparam logic [7:0] PROTO_ICMPV6  = 8'd58;

	// fixed byte offsets
	localparam int V4_PROTO_POS  = 9;
	localparam int V4_SRC_POS    = 12;
	localparam int V4_DST_POS    = 16;
	localparam int V4_MIN_LEN    = 20;
	localparam int V4_MIN_IHL    = 5;
	localparam int V6_NH_POS     = 6;
	localparam int V6_SRC_POS    = 8;
	localparam int V6_DST_POS    = 24;
	localparam int V6_HDR_LEN    = 40;

	// transport field offsets and minimum lengths
	localparam int TP_PORT_BYTES = 4;
	localparam int TP_TYPE_POS   = 0;
	localparam int TP_CODE_POS   = 1;
	localparam int TP_FLAGS_POS  = 13;
	localparam int TCP_MIN_LEN   = 20;
	localparam int UDP_MIN_LEN   = 8;
	localparam int ICMP_MIN_LEN  = 4;

	// one extension header unit is eight bytes
	localparam int EXT_UNIT      = 8;
	localparam int EXT_MAX_BYTES = 2048;

	typedef struct packed {
		logic        ok;
		logic        is_v6;
		logic [7:0]  protocol;
		logic [63:0] src_ip_hi;
		logic [63:0] src_ip_lo;
		logic [63:0] dst_ip_hi;
		logic [63:0] dst_ip_lo;
		logic [15:0] l4_sport;
		logic [15:0] l4_dport;
		logic [7:0]  tcp_ctl;
		logic [7:0]  msg_type;
		logic [7:0]  msg_code;
	} result_t;

	function automatic logic is_ext_header(input logic [7:0] nh);
		return (nh == NH_HOP_BY_HOP) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT) ||
			(nh == NH_AUTH) || (nh == NH_DEST_OPT);
	endfunction

endpackage

`default_nettype wire

### rtl/ipftp_byte_track.sv
// Per-packet parse state and its update for one byte word.
// Captures addresses, protocol and transport bytes, walks IPv6 extension headers.
// Depends on ipftp_pkg.
`default_nettype none

module ipftp_byte_track #(
	parameter int MAX_PACKET_BYTES = ipftp_pkg::MAX_PACKET_BYTES_DEF,
	parameter int MAX_EXT_HEADERS  = ipftp_pkg::MAX_EXT_HEADERS_DEF,
	localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1),
	localparam int EXT_W  = $clog2(MAX_PACKET_BYTES + ipftp_pkg::EXT_MAX_BYTES + 1),
	localparam int SEEN_W = $clog2(MAX_EXT_HEADERS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last,
	input  wire logic              opcode,
	output logic [POS_W-1:0]       n_len,
	output logic                   n_mode_v6,
	output logic                   n_header_ok,
	output logic [3:0]             n_hlw,
	output logic [7:0]             n_next_header,
	output logic                   n_walk_done,
	output logic [EXT_W-1:0]       n_transport_start,
	output logic [63:0]            n_src_hi,
	output logic [63:0]            n_src_lo,
	output logic [63:0]            n_dst_hi,
	output logic [63:0]            n_dst_lo,
	output logic [31:0]            n_port_pair,
	output logic [23:0]            n_flag_icmp
);

	logic [POS_W-1:0]  byte_index_q;
	logic              mode_v6_q;
	logic              header_ok_q;
	logic [3:0]        hlw_q;
	logic [7:0]        next_header_q;
	logic [EXT_W-1:0]  ext_start_q;
	logic [SEEN_W-1:0] ext_seen_q;
	logic              walk_done_q;
	logic [EXT_W-1:0]  transport_start_q;
	logic [63:0]       src_hi_q, src_lo_q, dst_hi_q, dst_lo_q;
	logic [31:0]       port_pair_q;
	logic [23:0]       flag_icmp_q;
	logic [7:0]        pending_q;

	logic [EXT_W-1:0]  n_ext_start;
	logic [SEEN_W-1:0] n_ext_seen;
	logic [7:0]        n_pending;
	logic [POS_W-1:0]  pos;
	logic [EXT_W-1:0]  pos_x;
	logic [EXT_W-1:0]  rel;
	logic              mode;

	assign pos   = byte_index_q;
	assign pos_x = EXT_W'(pos);
	assign rel   = pos_x - transport_start_q;
	assign mode  = (pos == '0) ? opcode : mode_v6_q;

	always_comb begin
		n_len             = byte_index_q;
		n_mode_v6         = mode_v6_q;
		n_header_ok       = header_ok_q;
		n_hlw             = hlw_q;
		n_next_header     = next_header_q;
		n_ext_start       = ext_start_q;
		n_ext_seen        = ext_seen_q;
		n_walk_done       = walk_done_q;
		n_transport_start = transport_start_q;
		n_src_hi          = src_hi_q;
		n_src_lo          = src_lo_q;
		n_dst_hi          = dst_hi_q;
		n_dst_lo          = dst_lo_q;
		n_port_pair       = port_pair_q;
		n_flag_icmp       = flag_icmp_q;
		n_pending         = pending_q;

		// bytes past the saturation point leave the state alone
		if (pos < POS_W'(MAX_PACKET_BYTES)) begin
			n_len     = pos + POS_W'(1);
			n_mode_v6 = mode;

			// transport capture runs on the start offset fixed by earlier words
			if (walk_done_q && (pos_x >= transport_start_q)) begin
				if (rel < EXT_W'(ipftp_pkg::TP_PORT_BYTES))
					n_port_pair = {port_pair_q[23:0], data_byte};
				if (rel == EXT_W'(ipftp_pkg::TP_TYPE_POS))
					n_flag_icmp[15:8] = data_byte;
				if (rel == EXT_W'(ipftp_pkg::TP_CODE_POS))
					n_flag_icmp[7:0] = data_byte;
				if (rel == EXT_W'(ipftp_pkg::TP_FLAGS_POS))
					n_flag_icmp[23:16] = data_byte;
			end

			if (!mode) begin
				if (pos == '0) begin
					n_header_ok       = (data_byte[7:4] == ipftp_pkg::VER_V4);
					n_hlw             = data_byte[3:0];
					n_transport_start = EXT_W'({data_byte[3:0], 2'b00});
					n_walk_done       = 1'b1;
				end else if (pos == POS_W'(ipftp_pkg::V4_PROTO_POS)) begin
					n_next_header = data_byte;
				end else if ((pos >= POS_W'(ipftp_pkg::V4_SRC_POS)) &&
						(pos < POS_W'(ipftp_pkg::V4_DST_POS))) begin
					n_src_lo = {32'd0, src_lo_q[23:0], data_byte};
				end else if ((pos >= POS_W'(ipftp_pkg::V4_DST_POS)) &&
						(pos < POS_W'(ipftp_pkg::V4_MIN_LEN))) begin
					n_dst_lo = {32'd0, dst_lo_q[23:0], data_byte};
				end
			end else begin
				if (pos == '0) begin
					n_header_ok = (data_byte[7:4] == ipftp_pkg::VER_V6);
				end else if (pos == POS_W'(ipftp_pkg::V6_NH_POS)) begin
					n_next_header = data_byte;
				end else if ((pos >= POS_W'(ipftp_pkg::V6_SRC_POS)) &&
						(pos < POS_W'(ipftp_pkg::V6_SRC_POS + 8))) begin
					n_src_hi = {src_hi_q[55:0], data_byte};
				end else if ((pos >= POS_W'(ipftp_pkg::V6_SRC_POS + 8)) &&
						(pos < POS_W'(ipftp_pkg::V6_DST_POS))) begin
					n_src_lo = {src_lo_q[55:0], data_byte};
				end else if ((pos >= POS_W'(ipftp_pkg::V6_DST_POS)) &&
						(pos < POS_W'(ipftp_pkg::V6_DST_POS + 8))) begin
					n_dst_hi = {dst_hi_q[55:0], data_byte};
				end else if ((pos >= POS_W'(ipftp_pkg::V6_DST_POS + 8)) &&
						(pos < POS_W'(ipftp_pkg::V6_HDR_LEN))) begin
					n_dst_lo = {dst_lo_q[55:0], data_byte};
				end

				// extension walk: first byte is the next header, second the length
				if (!walk_done_q && (pos >= POS_W'(ipftp_pkg::V6_HDR_LEN))) begin
					if (pos_x == ext_start_q) begin
						n_pending = data_byte;
					end else if (pos_x == ext_start_q + EXT_W'(1)) begin
						if (next_header_q == ipftp_pkg::NH_FRAGMENT)
							n_ext_start = ext_start_q + EXT_W'(ipftp_pkg::EXT_UNIT);
						else
							n_ext_start = ext_start_q + EXT_W'({data_byte, 3'b000}) +
								EXT_W'(ipftp_pkg::EXT_UNIT);
						n_next_header = pending_q;
						n_ext_seen    = ext_seen_q + SEEN_W'(1);
					end
				end

				// stop at a non-extension header or at the header limit
				if (!walk_done_q && (pos >= POS_W'(ipftp_pkg::V6_NH_POS)) &&
						(!ipftp_pkg::is_ext_header(n_next_header) ||
						(n_ext_seen >= SEEN_W'(MAX_EXT_HEADERS)))) begin
					n_walk_done       = 1'b1;
					n_transport_start = n_ext_start;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q      <= '0;
			mode_v6_q         <= 1'b0;
			header_ok_q       <= 1'b1;
			hlw_q             <= '0;
			next_header_q     <= '0;
			ext_start_q       <= EXT_W'(ipftp_pkg::V6_HDR_LEN);
			ext_seen_q        <= '0;
			walk_done_q       <= 1'b0;
			transport_start_q <= '0;
			src_hi_q          <= '0;
			src_lo_q          <= '0;
			dst_hi_q          <= '0;
			dst_lo_q          <= '0;
			port_pair_q       <= '0;
			flag_icmp_q       <= '0;
			pending_q         <= '0;
		end else if (take) begin
			if (last) begin
				// end of packet: drop all per-packet state
				byte_index_q      <= '0;
				mode_v6_q         <= 1'b0;
				header_ok_q       <= 1'b1;
				hlw_q             <= '0;
				next_header_q     <= '0;
				ext_start_q       <= EXT_W'(ipftp_pkg::V6_HDR_LEN);
				ext_seen_q        <= '0;
				walk_done_q       <= 1'b0;
				transport_start_q <= '0;
				src_hi_q          <= '0;
				src_lo_q          <= '0;
				dst_hi_q          <= '0;
				dst_lo_q          <= '0;
				port_pair_q       <= '0;
				flag_icmp_q       <= '0;
				pending_q         <= '0;
			end else begin
				byte_index_q      <= n_len;
				mode_v6_q         <= n_mode_v6;
				header_ok_q       <= n_header_ok;
				hlw_q             <= n_hlw;
				next_header_q     <= n_next_header;
				ext_start_q       <= n_ext_start;
				ext_seen_q        <= n_ext_seen;
				walk_done_q       <= n_walk_done;
				transport_start_q <= n_transport_start;
				src_hi_q          <= n_src_hi;
				src_lo_q          <= n_src_lo;
				dst_hi_q          <= n_dst_hi;
				dst_lo_q          <= n_dst_lo;
				port_pair_q       <= n_port_pair;
				flag_icmp_q       <= n_flag_icmp;
				pending_q         <= n_pending;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/ipftp_emit.sv
// Length checks and result formation from the end-of-packet snapshot.
// Zeroes every field of a rejected packet.
// Depends on ipftp_pkg.
`default_nettype none

module ipftp_emit #(
	parameter int MAX_PACKET_BYTES = ipftp_pkg::MAX_PACKET_BYTES_DEF,
	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1),
	localparam int EXT_W = $clog2(MAX_PACKET_BYTES + ipftp_pkg::EXT_MAX_BYTES + 1)
) (
	input  wire logic [POS_W-1:0] len,
	input  wire logic             mode_v6,
	input  wire logic             header_ok,
	input  wire logic [3:0]       hlw,
	input  wire logic [7:0]       next_header,
	input  wire logic             walk_done,
	input  wire logic [EXT_W-1:0] transport_start,
	input  wire logic [63:0]      src_hi,
	input  wire logic [63:0]      src_lo,
	input  wire logic [63:0]      dst_hi,
	input  wire logic [63:0]      dst_lo,
	input  wire logic [31:0]      port_pair,
	input  wire logic [23:0]      flag_icmp,
	output ipftp_pkg::result_t    result
);

	logic [EXT_W-1:0] len_x;
	logic [EXT_W-1:0] tlen;
	logic [7:0]       icmp_proto;
	logic             ts_fits;
	logic             net_ok;
	logic             ok;
	logic             is_tcp, is_udp, is_icmp;

	assign len_x      = EXT_W'(len);
	assign ts_fits    = (transport_start <= len_x);
	assign tlen       = ts_fits ? (len_x - transport_start) : '0;
	assign icmp_proto = mode_v6 ? ipftp_pkg::PROTO_ICMPV6 : ipftp_pkg::PROTO_ICMP;
	assign is_tcp     = (next_header == ipftp_pkg::PROTO_TCP);
	assign is_udp     = (next_header == ipftp_pkg::PROTO_UDP);
	assign is_icmp    = (next_header == icmp_proto);

	always_comb begin
		if (mode_v6)
			net_ok = (len_x >= EXT_W'(ipftp_pkg::V6_HDR_LEN)) && header_ok && walk_done &&
				ts_fits;
		else
			net_ok = (len_x >= EXT_W'(ipftp_pkg::V4_MIN_LEN)) && header_ok &&
				(hlw >= 4'(ipftp_pkg::V4_MIN_IHL)) && (len_x >= EXT_W'({hlw, 2'b00}));
	end

	assign ok = net_ok &&
		!(is_tcp && (tlen < EXT_W'(ipftp_pkg::TCP_MIN_LEN))) &&
		!(is_udp && (tlen < EXT_W'(ipftp_pkg::UDP_MIN_LEN))) &&
		!(is_icmp && (tlen < EXT_W'(ipftp_pkg::ICMP_MIN_LEN)));

	always_comb begin
		result = '0;
		if (ok) begin
			result.ok        = 1'b1;
			result.is_v6     = mode_v6;
			result.protocol  = next_header;
			result.src_ip_hi = src_hi;
			result.src_ip_lo = src_lo;
			result.dst_ip_hi = dst_hi;
			result.dst_ip_lo = dst_lo;
			if (is_tcp || is_udp) begin
				result.l4_sport = port_pair[31:16];
				result.l4_dport = port_pair[15:0];
			end
			if (is_tcp)
				result.tcp_ctl = flag_icmp[23:16];
			if (is_icmp) begin
				result.msg_type = flag_icmp[15:8];
				result.msg_code = flag_icmp[7:0];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/ip_five_tuple_parser.sv
// Top level of the IPv4 / IPv6 five-tuple parser: handshakes, snapshot and result registers.
// Depends on ipftp_pkg, ipftp_byte_track and ipftp_emit.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  data_byte, last, opcode (one byte word per transfer)
// result    out        out_valid / out_stall ok, is_v6, protocol, addresses, ports, flags, ICMP
//
// One byte word is taken every cycle while in_stall is low; parse state updates in the same cycle.
// The word with last set snapshots the final state (_s1); the result register (_s2)
// then takes the result formed from that snapshot once the result side is not stalled.
// Reset clears all parse state and both valid flags; no clearing pass is needed.
// Input stalls only while a snapshot waits behind a stalled result.
`default_nettype none

module ip_five_tuple_parser #(
	parameter int MAX_PACKET_BYTES = ipftp_pkg::MAX_PACKET_BYTES_DEF,
	parameter int MAX_EXT_HEADERS  = ipftp_pkg::MAX_EXT_HEADERS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last,
	input  wire logic        opcode,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic             is_v6,
	output logic [7:0]       protocol,
	output logic [63:0]      src_ip_hi,
	output logic [63:0]      src_ip_lo,
	output logic [63:0]      dst_ip_hi,
	output logic [63:0]      dst_ip_lo,
	output logic [15:0]      l4_sport,
	output logic [15:0]      l4_dport,
	output logic [7:0]       tcp_ctl,
	output logic [7:0]       msg_type,
	output logic [7:0]       msg_code
);

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int EXT_W = $clog2(MAX_PACKET_BYTES + ipftp_pkg::EXT_MAX_BYTES + 1);

	logic             take;
	logic             adv_s1;
	logic             vld_s1;

	logic [POS_W-1:0] n_len;
	logic             n_mode_v6, n_header_ok, n_walk_done;
	logic [3:0]       n_hlw;
	logic [7:0]       n_next_header;
	logic [EXT_W-1:0] n_transport_start;
	logic [63:0]      n_src_hi, n_src_lo, n_dst_hi, n_dst_lo;
	logic [31:0]      n_port_pair;
	logic [23:0]      n_flag_icmp;

	logic [POS_W-1:0] len_s1;
	logic             mode_v6_s1, header_ok_s1, walk_done_s1;
	logic [3:0]       hlw_s1;
	logic [7:0]       next_header_s1;
	logic [EXT_W-1:0] transport_start_s1;
	logic [63:0]      src_hi_s1, src_lo_s1, dst_hi_s1, dst_lo_s1;
	logic [31:0]      port_pair_s1;
	logic [23:0]      flag_icmp_s1;

	ipftp_pkg::result_t result;
	ipftp_pkg::result_t res_s2;

	assign adv_s1   = !out_valid || !out_stall;
	assign in_stall = vld_s1 && !adv_s1;
	assign take     = in_valid && !in_stall;

	ipftp_byte_track #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES),
		.MAX_EXT_HEADERS  (MAX_EXT_HEADERS)
	) u_track (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (take),
		.data_byte         (data_byte),
		.last              (last),
		.opcode            (opcode),
		.n_len             (n_len),
		.n_mode_v6         (n_mode_v6),
		.n_header_ok       (n_header_ok),
		.n_hlw             (n_hlw),
		.n_next_header     (n_next_header),
		.n_walk_done       (n_walk_done),
		.n_transport_start (n_transport_start),
		.n_src_hi          (n_src_hi),
		.n_src_lo          (n_src_lo),
		.n_dst_hi          (n_dst_hi),
		.n_dst_lo          (n_dst_lo),
		.n_port_pair       (n_port_pair),
		.n_flag_icmp       (n_flag_icmp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= (take && last) || (vld_s1 && !adv_s1);
	end

	// snapshot the final packet state; held while the result side is stalled
	always_ff @(posedge clk) begin
		if (take && last) begin
			len_s1             <= n_len;
			mode_v6_s1         <= n_mode_v6;
			header_ok_s1       <= n_header_ok;
			hlw_s1             <= n_hlw;
			next_header_s1     <= n_next_header;
			walk_done_s1       <= n_walk_done;
			transport_start_s1 <= n_transport_start;
			src_hi_s1          <= n_src_hi;
			src_lo_s1          <= n_src_lo;
			dst_hi_s1          <= n_dst_hi;
			dst_lo_s1          <= n_dst_lo;
			port_pair_s1       <= n_port_pair;
			flag_icmp_s1       <= n_flag_icmp;
		end
	end

	ipftp_emit #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_emit (
		.len             (len_s1),
		.mode_v6         (mode_v6_s1),
		.header_ok       (header_ok_s1),
		.hlw             (hlw_s1),
		.next_header     (next_header_s1),
		.walk_done       (walk_done_s1),
		.transport_start (transport_start_s1),
		.src_hi          (src_hi_s1),
		.src_lo          (src_lo_s1),
		.dst_hi          (dst_hi_s1),
		.dst_lo          (dst_lo_s1),
		.port_pair       (port_pair_s1),
		.flag_icmp       (flag_icmp_s1),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv_s1)
			out_valid <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1)
			res_s2 <= result;
	end

	assign ok        = res_s2.ok;
	assign is_v6     = res_s2.is_v6;
	assign protocol  = res_s2.protocol;
	assign src_ip_hi = res_s2.src_ip_hi;
	assign src_ip_lo = res_s2.src_ip_lo;
	assign dst_ip_hi = res_s2.dst_ip_hi;
	assign dst_ip_lo = res_s2.dst_ip_lo;
	assign l4_sport  = res_s2.l4_sport;
	assign l4_dport  = res_s2.l4_dport;
	assign tcp_ctl   = res_s2.tcp_ctl;
	assign msg_type  = res_s2.msg_type;
	assign msg_code  = res_s2.msg_code;

endmodule

`default_nettype wire
